FILE: hw/rtl/tsg_pkg.sv
// shared constants, register codes and sine table builder for the tone sample generator
package tsg_pkg;

  // field widths
  localparam int INDEX_W  = 32;
  localparam int STEP_W   = 31;
  localparam int AMP_W    = 15;
  localparam int MAG_W    = 15;
  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = AMP_W + MAG_W;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = AMP_W;

  localparam logic [CFG_INDEX_W-1:0] REG_WAVE_SHAPE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE  = 2'd1;

  localparam logic SHAPE_SINE   = 1'b0;
  localparam logic SHAPE_SQUARE = 1'b1;

  localparam logic [AMP_W-1:0] AMPLITUDE_RESET = 15'd9830;

  // default sizes
  localparam int PHASE_BITS_DEF      = 32;
  localparam int TABLE_ADDR_BITS_DEF = 10;

  // fixed point constants for the table builder
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam logic [63:0] SAMPLE_MAX  = 64'd32767;

  // magnitude of the quarter-wave sine entry idx, Q1.15, evaluated at elaboration
  function automatic logic [MAG_W-1:0] sine_quarter_mag(input int unsigned idx,
                                                        input int unsigned addr_bits);
    logic [63:0] half;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] mag;
    half = 64'd1 << (addr_bits - 3);
    x    = (64'(idx) * Q30_HALF_PI + half) >> (addr_bits - 2);
    x2   = (x * x) >> 30;
    // taylor series in horner form
    t    = Q30_ONE;
    t    = Q30_ONE - (((x2 * t) >> 30) / 64'd156);
    t    = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
    t    = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
    t    = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
    t    = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
    t    = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
    s    = (x * t) >> 30;
    mag  = (s * 64'd32768 + (64'd1 << 29)) >> 30;
    if (mag > SAMPLE_MAX) begin
      mag = SAMPLE_MAX;
    end
    return mag[MAG_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/tone_sample_generator_unit.sv
// top level of the tone sample generator: configuration registers and pipeline
//
// Direct digital synthesis of a sine or square tone, one stereo PCM sample per
// request. The phase is phase_step * sample_index modulo 2^PHASE_BITS; its top
// TABLE_ADDR_BITS address a quarter-wave Q1.15 sine table, and the entry is
// scaled by the amplitude register and truncated toward zero. In square mode
// the sample is +amplitude while the phase MSB is clear and -amplitude while
// it is set. Both channels carry the same value and last follows its request.
// The block takes one request per cycle while in_stall is low, and each request
// passes through the register stages in order: two stages for the split
// step-by-index multiply and phase sum, one for the registered table read,
// two for the amplitude multiply and final sign/shape select. The stall path
// is combinational through all stages, so the input stalls in the same cycle
// as the output only when every stage holds a request; empty stages keep
// filling while the output waits.
// Configuration writes complete in the cycle they are offered and must only
// be made while no request is in flight.
module tone_sample_generator_unit
  import tsg_pkg::*;
#(
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [INDEX_W-1:0]     in_sample_index,
  input  logic [STEP_W-1:0]      in_phase_step,
  input  logic                   in_last_in_buffer,
  // sample channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_W-1:0]    out_left_sample,
  output logic [SAMPLE_W-1:0]    out_right_sample,
  output logic                   out_last,
  // configuration write port
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic             wave_shape_r;
  logic [AMP_W-1:0] amplitude_r;

  // phase stages to table
  logic                       ph_valid;
  logic                       ph_ready;
  logic [TABLE_ADDR_BITS-1:0] ph_addr;
  logic                       ph_last;

  // table to scaling stages
  logic             lk_valid;
  logic             lk_ready;
  logic [MAG_W-1:0] lk_mag;
  logic             lk_neg;
  logic             lk_last;

  logic                in_ready;
  logic [SAMPLE_W-1:0] sample;

  // writes never wait
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_shape_r <= SHAPE_SINE;
      amplitude_r  <= AMPLITUDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WAVE_SHAPE: wave_shape_r <= cfg_data[0];
        REG_AMPLITUDE:  amplitude_r  <= cfg_data[AMP_W-1:0];
        // indexes beyond the register list are dropped
        default: ;
      endcase
    end
  end

  assign in_stall = !in_ready;

  // step * index, reduced to the table address
  tsg_phase #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_phase (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (in_valid),
    .up_ready     (in_ready),
    .sample_index (in_sample_index),
    .phase_step   (in_phase_step),
    .last_in      (in_last_in_buffer),
    .dn_valid     (ph_valid),
    .dn_ready     (ph_ready),
    .table_addr   (ph_addr),
    .last_out     (ph_last)
  );

  // sine magnitude and sign; the sign is also the square wave level
  tsg_sine_lookup #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_lookup (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (ph_valid),
    .up_ready   (ph_ready),
    .table_addr (ph_addr),
    .last_in    (ph_last),
    .dn_valid   (lk_valid),
    .dn_ready   (lk_ready),
    .mag        (lk_mag),
    .neg        (lk_neg),
    .last_out   (lk_last)
  );

  // amplitude scaling and output register
  tsg_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (lk_valid),
    .up_ready   (lk_ready),
    .mag        (lk_mag),
    .neg        (lk_neg),
    .last_in    (lk_last),
    .wave_shape (wave_shape_r),
    .amplitude  (amplitude_r),
    .dn_valid   (out_valid),
    .dn_ready   (!out_stall),
    .sample     (sample),
    .last_out   (out_last)
  );

  // stereo pair carries the same sample
  assign out_left_sample  = sample;
  assign out_right_sample = sample;

endmodule

FILE: hw/rtl/tsg_phase.sv
// phase stages: split multiply of step by index, then partial product sum
module tsg_phase
  import tsg_pkg::*;
#(
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic [INDEX_W-1:0]         sample_index,
  input  logic [STEP_W-1:0]          phase_step,
  input  logic                       last_in,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output logic [TABLE_ADDR_BITS-1:0] table_addr,
  output logic                       last_out
);

  localparam int HALF_W = INDEX_W / 2;
  localparam int PP_W   = STEP_W + HALF_W;
  localparam int SUM_W  = STEP_W + INDEX_W;

  logic              v1_r;
  logic [PP_W-1:0]   plo_r;
  logic [PP_W-1:0]   phi_r;
  logic              last1_r;
  logic              v2_r;
  logic [TABLE_ADDR_BITS-1:0] addr_r;
  logic              last2_r;
  logic              ld1;
  logic              ld2;
  logic [SUM_W-1:0]  phase_sum;

  assign ld2      = !v2_r || dn_ready;
  assign ld1      = !v1_r || ld2;
  assign up_ready = ld1;

  // full product, only the low PHASE_BITS matter
  assign phase_sum = SUM_W'(plo_r) + (SUM_W'(phi_r) << HALF_W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (ld1) begin
        v1_r <= up_valid;
      end
      if (ld2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1 && up_valid) begin
      plo_r   <= PP_W'(phase_step) * PP_W'(sample_index[HALF_W-1:0]);
      phi_r   <= PP_W'(phase_step) * PP_W'(sample_index[INDEX_W-1:HALF_W]);
      last1_r <= last_in;
    end
    if (ld2 && v1_r) begin
      addr_r  <= phase_sum[PHASE_BITS-1 -: TABLE_ADDR_BITS];
      last2_r <= last1_r;
    end
  end

  assign dn_valid   = v2_r;
  assign table_addr = addr_r;
  assign last_out   = last2_r;

endmodule

FILE: hw/rtl/tsg_sine_lookup.sv
// quarter-wave sine table with registered read
module tsg_sine_lookup
  import tsg_pkg::*;
#(
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic [TABLE_ADDR_BITS-1:0] table_addr,
  input  logic                       last_in,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output logic [MAG_W-1:0]           mag,
  output logic                       neg,
  output logic                       last_out
);

  localparam int QUARTER = 1 << (TABLE_ADDR_BITS - 2);
  localparam int IDX_W   = TABLE_ADDR_BITS - 1;
  localparam logic [IDX_W-1:0] QUARTER_IDX = IDX_W'(QUARTER);

  logic [MAG_W-1:0] rom [QUARTER+1];
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] qidx;
  logic             v_r;
  logic [MAG_W-1:0] mag_r;
  logic             neg_r;
  logic             last_r;
  logic             ld;

  for (genvar i = 0; i <= QUARTER; i++) begin : g_rom
    assign rom[i] = sine_quarter_mag(i, TABLE_ADDR_BITS);
  end

  // mirror the offset in the second and fourth quadrants
  assign k    = IDX_W'(table_addr[TABLE_ADDR_BITS-3:0]);
  assign qidx = table_addr[TABLE_ADDR_BITS-2] ? (QUARTER_IDX - k) : k;

  assign ld       = !v_r || dn_ready;
  assign up_ready = ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ld) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld && up_valid) begin
      mag_r  <= rom[qidx];
      neg_r  <= table_addr[TABLE_ADDR_BITS-1];
      last_r <= last_in;
    end
  end

  assign dn_valid = v_r;
  assign mag      = mag_r;
  assign neg      = neg_r;
  assign last_out = last_r;

endmodule

FILE: hw/rtl/tsg_scale.sv
// amplitude scaling, sign restore and waveform select with output register
module tsg_scale
  import tsg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic [MAG_W-1:0]    mag,
  input  logic                neg,
  input  logic                last_in,
  input  logic                wave_shape,
  input  logic [AMP_W-1:0]    amplitude,
  output logic                dn_valid,
  input  logic                dn_ready,
  output logic [SAMPLE_W-1:0] sample,
  output logic                last_out
);

  logic                v1_r;
  logic [PROD_W-1:0]   prod_r;
  logic                neg1_r;
  logic                last1_r;
  logic                v2_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic                last2_r;
  logic                ld1;
  logic                ld2;
  logic [AMP_W-1:0]    mag_sel;
  logic [SAMPLE_W-1:0] sample_nxt;

  assign ld2      = !v2_r || dn_ready;
  assign ld1      = !v1_r || ld2;
  assign up_ready = ld1;

  // truncation toward zero: scale the magnitude, then restore the sign
  always_comb begin
    unique case (wave_shape)
      SHAPE_SQUARE: mag_sel = amplitude;
      default:      mag_sel = prod_r[PROD_W-1:MAG_W];
    endcase
    sample_nxt = neg1_r ? (SAMPLE_W'(0) - SAMPLE_W'(mag_sel)) : SAMPLE_W'(mag_sel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (ld1) begin
        v1_r <= up_valid;
      end
      if (ld2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1 && up_valid) begin
      prod_r  <= PROD_W'(mag) * PROD_W'(amplitude);
      neg1_r  <= neg;
      last1_r <= last_in;
    end
    if (ld2 && v1_r) begin
      sample_r <= sample_nxt;
      last2_r  <= last1_r;
    end
  end

  assign dn_valid = v2_r;
  assign sample   = sample_r;
  assign last_out = last2_r;

endmodule

FILE: test/tone_sample_generator_unit_tb.sv
// self-checking testbench for the tone sample generator: directed table, random buffer fills
module tone_sample_generator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tsg_pkg::*;

  localparam int          TONE_PHASE_BITS = PHASE_BITS_DEF;
  localparam int          TONE_ADDR_BITS  = TABLE_ADDR_BITS_DEF;
  localparam int          QUARTER_LEN     = 1 << (TONE_ADDR_BITS - 2);
  localparam bit [63:0]   ONE_Q30         = 64'd1 << 30;
  localparam bit [63:0]   HALF_PI_Q30     = 64'd1686629713;
  localparam int          RAND_PHASES     = 8;
  localparam int          ITEMS_PER_PHASE = 210;
  localparam int          LONG_HOLD       = 100;
  localparam int          CYCLE_LIMIT     = 1000000;
  localparam int          SETTLE_CYCLES   = 16;

  // register indexes past the end of the list, the block must ignore them
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_3 = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] pcm;
    logic                last;
  } tone_sample_t;

  // one row of the directed table: settings, request, and optionally a typed-in answer
  typedef struct {
    logic                shape;
    logic [AMP_W-1:0]    amp;
    logic [INDEX_W-1:0]  idx;
    logic [STEP_W-1:0]   step;
    logic                last;
    bit                  known;
    logic [SAMPLE_W-1:0] known_pcm;
  } tone_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [INDEX_W-1:0]     in_sample_index = '0;
  logic [STEP_W-1:0]      in_phase_step = '0;
  logic                   in_last_in_buffer = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [SAMPLE_W-1:0]    out_left_sample;
  logic [SAMPLE_W-1:0]    out_right_sample;
  logic                   out_last;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor copy of the registers and the quarter-wave table
  logic                   tone_shape;
  logic [AMP_W-1:0]       tone_amp;
  logic [MAG_W-1:0]       quarter_mag [0:QUARTER_LEN];

  tone_sample_t           pending_samples [$];
  tone_row_t              directed_rows [$];
  int                     error_count = 0;
  bit                     calm = 1'b0;
  bit                     long_hold_req = 1'b0;

  tone_sample_generator_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_index   (in_sample_index),
    .in_phase_step     (in_phase_step),
    .in_last_in_buffer (in_last_in_buffer),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_left_sample   (out_left_sample),
    .out_right_sample  (out_right_sample),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin : clock_gen
    forever begin
      #10 clk = ~clk;
    end
  end

  // hard stop if the run hangs
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // sine magnitude for quarter-wave position n, Q1.15, taylor series in Q30
  function automatic logic [MAG_W-1:0] quarter_wave_mag(input int unsigned n);
    bit [63:0] ang;
    bit [63:0] ang_sq;
    bit [63:0] acc;
    bit [63:0] prod;
    bit [63:0] rnd;
    int unsigned divs [0:5];
    divs = '{156, 110, 72, 42, 20, 6};
    ang = (64'(n) * HALF_PI_Q30 + (64'd1 << (TONE_ADDR_BITS - 3))) >> (TONE_ADDR_BITS - 2);
    ang_sq = (ang * ang) >> 30;
    acc = ONE_Q30;
    for (int i = 0; i < 6; i++) begin
      acc = ONE_Q30 - (((ang_sq * acc) >> 30) / 64'(divs[i]));
    end
    prod = (ang * acc) >> 30;
    rnd = (prod * 64'd32768 + (64'd1 << 29)) >> 30;
    return (rnd > 64'd32767) ? {MAG_W{1'b1}} : rnd[MAG_W-1:0];
  endfunction

  // expected pcm sample for one request under the current register settings
  function automatic tone_sample_t predict_tone_sample(input logic [INDEX_W-1:0] idx,
                                                       input logic [STEP_W-1:0] step,
                                                       input logic last);
    bit [63:0]                  prod;
    bit [TONE_PHASE_BITS-1:0]   phase;
    bit [TONE_ADDR_BITS-1:0]    addr;
    bit [TONE_ADDR_BITS-2:0]    qidx;
    bit [PROD_W-1:0]            scaled;
    bit [SAMPLE_W-1:0]          mag;
    bit                         negate;
    tone_sample_t               r;
    prod = 64'(idx) * 64'(step);
    phase = prod[TONE_PHASE_BITS-1:0];
    if (tone_shape == SHAPE_SQUARE) begin
      // sign follows the phase msb
      mag = {1'b0, tone_amp};
      negate = phase[TONE_PHASE_BITS-1];
    end else begin
      addr = phase[TONE_PHASE_BITS-1 -: TONE_ADDR_BITS];
      // odd quadrants run the quarter table backwards
      if (addr[TONE_ADDR_BITS-2]) begin
        qidx = (TONE_ADDR_BITS-1)'(QUARTER_LEN) - {1'b0, addr[TONE_ADDR_BITS-3:0]};
      end else begin
        qidx = {1'b0, addr[TONE_ADDR_BITS-3:0]};
      end
      scaled = PROD_W'(quarter_mag[qidx]) * PROD_W'(tone_amp);
      // magnitude is scaled, so the sign flip truncates toward zero
      mag = {1'b0, scaled[PROD_W-1:AMP_W]};
      negate = addr[TONE_ADDR_BITS-1];
    end
    r.pcm = negate ? -mag : mag;
    r.last = last;
    return r;
  endfunction

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t: mismatch: %s", $time, what);
    end
  endtask

  // gap length: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 2);
    end else if (r < 95) begin
      return $urandom_range(3, 8);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [INDEX_W-1:0] random_index();
    case ($urandom_range(0, 3))
      0: begin
        return 32'hFFFF_FFFF - $urandom_range(0, 40);
      end
      1: begin
        return $urandom_range(0, 1000);
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] random_step();
    case ($urandom_range(0, 9))
      0: begin
        return '0;
      end
      1: begin
        return {STEP_W{1'b1}};
      end
      2, 3, 4, 5: begin
        // audible tone range
        return STEP_W'($urandom_range(1, 200000000));
      end
      default: begin
        return STEP_W'($urandom);
      end
    endcase
  endfunction

  // offer one request and hold it until accepted; called at a clock edge
  task automatic send_request(input logic [INDEX_W-1:0] idx, input logic [STEP_W-1:0] step,
                              input logic last, input bit known,
                              input logic [SAMPLE_W-1:0] known_pcm);
    int gap;
    tone_sample_t want;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_sample_index   <= idx;
    in_phase_step     <= step;
    in_last_in_buffer <= last;
    do begin
      @(posedge clk);
    end while (in_stall);
    if (known) begin
      want.pcm = known_pcm;
      want.last = last;
    end else begin
      want = predict_tone_sample(idx, step, last);
    end
    pending_samples.push_back(want);
  endtask

  // stop offering and wait for every sample in flight
  task automatic wait_for_samples();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // leaves cfg_valid high so back-to-back writes need no extra edge
  task automatic write_tone_reg(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    if (idx == REG_WAVE_SHAPE) begin
      tone_shape = data[0];
    end else if (idx == REG_AMPLITUDE) begin
      tone_amp = data[AMP_W-1:0];
    end
  endtask

  task automatic program_tone(input logic shape, input logic [AMP_W-1:0] amp);
    wait_for_samples();
    // junk in the upper bits of the shape write must be dropped
    write_tone_reg(REG_WAVE_SHAPE, {(CFG_DATA_W-1)'($urandom), shape});
    write_tone_reg(REG_AMPLITUDE, amp);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input logic shape, input logic [AMP_W-1:0] amp,
                         input logic [INDEX_W-1:0] idx, input logic [STEP_W-1:0] step,
                         input logic last, input bit known, input logic [SAMPLE_W-1:0] pcm);
    tone_row_t row;
    row.shape = shape;
    row.amp = amp;
    row.idx = idx;
    row.step = step;
    row.last = last;
    row.known = known;
    row.known_pcm = pcm;
    directed_rows.push_back(row);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin : sample_stall_gen
    int n;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = idle_len();
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // compare each accepted sample against the oldest expectation
  always @(posedge clk) begin : sample_checker
    tone_sample_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        flag_error($sformatf("sample %0d with no request pending", $signed(out_left_sample)));
      end else begin
        want = pending_samples.pop_front();
        if (out_left_sample !== want.pcm) begin
          flag_error($sformatf("left_sample expected %0d got %0d",
                               $signed(want.pcm), $signed(out_left_sample)));
        end
        if (out_right_sample !== want.pcm) begin
          flag_error($sformatf("right_sample expected %0d got %0d",
                               $signed(want.pcm), $signed(out_right_sample)));
        end
        if (out_last !== want.last) begin
          flag_error($sformatf("last expected %0b got %0b", want.last, out_last));
        end
      end
    end
  end

  initial begin : stimulus
    int              sent;
    int              len;
    int              kind;
    bit              paused;
    logic            shape;
    logic [AMP_W-1:0] amp;
    logic [INDEX_W-1:0] base;
    logic [STEP_W-1:0]  step;

    for (int i = 0; i <= QUARTER_LEN; i++) begin
      quarter_mag[i] = quarter_wave_mag(i);
    end

    // directed table: reset settings first, then extremes of both shapes
    add_row(SHAPE_SINE, AMPLITUDE_RESET, 32'd0, 31'd0, 1'b0, 1, 16'd0);
    add_row(SHAPE_SINE, AMPLITUDE_RESET, 32'd1, 31'h4000_0000, 1'b0, 0, '0);
    add_row(SHAPE_SINE, AMPLITUDE_RESET, 32'd3, 31'h4000_0000, 1'b1, 0, '0);
    add_row(SHAPE_SINE, AMPLITUDE_RESET, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 0, '0);
    // full scale sine: peak, zero crossing at half cycle, small angles
    add_row(SHAPE_SINE, 15'h7FFF, 32'd1, 31'h4000_0000, 1'b0, 0, '0);
    add_row(SHAPE_SINE, 15'h7FFF, 32'd2, 31'h4000_0000, 1'b0, 1, 16'd0);
    add_row(SHAPE_SINE, 15'h7FFF, 32'd5, 31'h0040_0000, 1'b0, 0, '0);
    add_row(SHAPE_SINE, 15'h7FFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 0, '0);
    add_row(SHAPE_SINE, 15'h7FFF, 32'h1234_5678, 31'd1, 1'b0, 0, '0);
    // zero amplitude silences everything
    add_row(SHAPE_SINE, 15'd0, 32'd1, 31'h4000_0000, 1'b0, 1, 16'd0);
    add_row(SHAPE_SINE, 15'd0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1, 16'd0);
    // square: zero step holds phase at 0, msb picks the sign
    add_row(SHAPE_SQUARE, 15'h7FFF, 32'd0, 31'd0, 1'b0, 1, 16'sd32767);
    add_row(SHAPE_SQUARE, 15'h7FFF, 32'hFFFF_FFFF, 31'd0, 1'b0, 1, 16'sd32767);
    add_row(SHAPE_SQUARE, 15'h7FFF, 32'd1, 31'h4000_0000, 1'b0, 1, 16'sd32767);
    add_row(SHAPE_SQUARE, 15'h7FFF, 32'd2, 31'h4000_0000, 1'b0, 1, -16'sd32767);
    add_row(SHAPE_SQUARE, 15'h7FFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1, -16'sd32767);
    add_row(SHAPE_SQUARE, 15'd0, 32'd2, 31'h4000_0000, 1'b0, 1, 16'd0);
    add_row(SHAPE_SQUARE, 15'd1, 32'd3, 31'h4000_0000, 1'b0, 1, -16'sd1);
    add_row(SHAPE_SQUARE, 15'd1, 32'd1, 31'd1, 1'b1, 1, 16'sd1);
    // smallest nonzero sine amplitude
    add_row(SHAPE_SINE, 15'd1, 32'd1, 31'h4000_0000, 1'b0, 0, '0);
    add_row(SHAPE_SINE, 15'd1, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 0, '0);

    // single reset pulse
    tone_shape = SHAPE_SINE;
    tone_amp = AMPLITUDE_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // writes to indexes past the register list must leave the settings alone
    write_tone_reg(REG_UNUSED_2, {CFG_DATA_W{1'b1}});
    write_tone_reg(REG_UNUSED_3, {CFG_DATA_W{1'b1}});
    cfg_valid <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].shape !== tone_shape || directed_rows[i].amp !== tone_amp) begin
        program_tone(directed_rows[i].shape, directed_rows[i].amp);
      end
      send_request(directed_rows[i].idx, directed_rows[i].step, directed_rows[i].last,
                   directed_rows[i].known, directed_rows[i].known_pcm);
    end

    // random phases, each with its own register settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin
          shape = SHAPE_SINE;
          amp = 15'h7FFF;
        end
        1: begin
          shape = SHAPE_SQUARE;
          amp = 15'h7FFF;
        end
        3: begin
          shape = SHAPE_SQUARE;
          amp = 15'd0;
        end
        4: begin
          shape = SHAPE_SINE;
          amp = 15'd1;
        end
        default: begin
          shape = $urandom_range(0, 1) ? SHAPE_SQUARE : SHAPE_SINE;
          amp = AMP_W'($urandom);
        end
      endcase
      program_tone(shape, amp);
      // calm phases: no sender gaps or random stalls; in phase 2 the receiver holds off once while requests keep coming
      calm = (p == 2 || p == 6);
      if (p == 2) begin
        long_hold_req = 1'b1;
      end
      sent = 0;
      paused = 1'b0;
      while (sent < ITEMS_PER_PHASE) begin
        // sender pause: let the pipeline run dry mid-phase
        if (p == 4 && !paused && sent >= ITEMS_PER_PHASE / 2) begin
          paused = 1'b1;
          wait_for_samples();
        end
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
          // well-formed buffer fill: consecutive indexes, one tone, last on the end
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(8, 32);
          base = random_index();
          step = random_step();
          for (int i = 0; i < len; i++) begin
            send_request(base + i, step, (i == len - 1), 0, '0);
          end
          sent += len;
        end else if (kind < 90) begin
          // broken fill: index jumps and stray last flags
          len = $urandom_range(2, 10);
          base = random_index();
          step = random_step();
          for (int i = 0; i < len; i++) begin
            send_request(base + $urandom_range(0, 3) * i, step, 1'($urandom_range(0, 1)),
                         0, '0);
          end
          sent += len;
        end else begin
          send_request($urandom, STEP_W'($urandom), 1'($urandom_range(0, 1)), 0, '0);
          sent++;
        end
      end
      calm = 1'b0;
    end

    wait_for_samples();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_samples.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
